FILE: design/pgc_pkg.sv
// package for the planar predictor with golomb parameter context
// holds field widths, register codes, modes and the activity-to-k mapping
// no dependencies
package pgc_pkg;

  localparam int SAMPLE_W          = 18;
  localparam int K_W               = 3;
  localparam int ROW_WIDTH_W       = 11;
  localparam int CFG_IDX_W         = 2;
  localparam int COEF_MAX_BITS     = 32;
  localparam int DEF_MAX_ROW_WIDTH = 1024;
  localparam int DEF_COEF_BITS     = 16;
  localparam int ROW_WIDTH_RESET   = 1024;
  localparam int ACT_LIMIT         = 32;
  localparam int ACT_W             = COEF_MAX_BITS + 1;

  localparam logic [K_W-1:0] K_EDGE = 3'd6;
  localparam logic [K_W-1:0] K_NONE = 3'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_ROW_WIDTH = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef enum logic {
    KIND_RAW    = 1'b0,
    KIND_GOLOMB = 1'b1
  } code_kind_t;

  function automatic logic [K_W-1:0] act_level(input logic [4:0] a);
    logic [K_W-1:0] k;
    case (a) inside
      5'd0:            k = 3'd0;
      5'd1:            k = 3'd1;
      [5'd2:5'd3]:     k = 3'd2;
      [5'd4:5'd7]:     k = 3'd3;
      [5'd8:5'd15]:    k = 3'd4;
      default:         k = 3'd5;
    endcase
    return k;
  endfunction

  // gradient activity of left/top around topleft, reduced by a quarter
  function automatic logic [K_W-1:0] activity_k(
    input logic signed [COEF_MAX_BITS-1:0] l,
    input logic signed [COEF_MAX_BITS-1:0] t,
    input logic signed [COEF_MAX_BITS-1:0] tl
  );
    logic signed [ACT_W-1:0] s1;
    logic signed [ACT_W-1:0] s2;
    logic [ACT_W-1:0] d1;
    logic [ACT_W-1:0] d2;
    logic [ACT_W:0] sum;
    logic [ACT_W:0] a;
    s1  = ACT_W'(l) - ACT_W'(tl);
    s2  = ACT_W'(t) - ACT_W'(tl);
    d1  = s1[ACT_W-1] ? ACT_W'(-s1) : ACT_W'(s1);
    d2  = s2[ACT_W-1] ? ACT_W'(-s2) : ACT_W'(s2);
    sum = {1'b0, d1} + {1'b0, d2};
    a   = sum - (sum >> 2);
    if (a >= (ACT_W + 1)'(ACT_LIMIT)) begin
      return K_EDGE;
    end
    return act_level(a[4:0]);
  endfunction

endpackage

FILE: design/pgc_if.sv
// channel interfaces: coefficient feed, result stream, configuration writes
// depends on pgc_pkg
interface pgc_feed_if import pgc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       band_start;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output band_start, output sample_in, input ready);
  modport sink   (input valid, input band_start, input sample_in, output ready);
endinterface

interface pgc_result_if import pgc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       code_kind;
  logic [K_W-1:0]             golomb_k;

  modport source (output valid, output sample_out, output code_kind, output golomb_k,
                  input ready);
  modport sink   (input valid, input sample_out, input code_kind, input golomb_k,
                  output ready);
endinterface

interface pgc_cfg_if import pgc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [ROW_WIDTH_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/pgc_line_store.sv
// previous-row line store: one write port, two registered read ports
// depends on pgc_pkg
module pgc_line_store
  import pgc_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_ROW_WIDTH,
  parameter int DATA_W = DEF_COEF_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [DATA_W-1:0]        rd_data_a,
  output logic [DATA_W-1:0]        rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: design/planar_prediction_golomb_context_top.sv
// planar predictor with golomb parameter context, top level
// depends on pgc_pkg, pgc_if (channel interfaces) and pgc_line_store
//
//   channel  dir   payload                                  handshake
//   feed     in    band_start, sample_in (s18)              valid/ready
//   result   out   sample_out (s18), code_kind, golomb_k    valid/ready
//   cfg      in    index (mode, row_width), data            valid/ready, always ready
//
// one item per cycle unless result stalls; items pass s1, then the output register
// two line-store reads per item at accept, one write as it leaves prediction,
// same-entry hazards are covered by forwarding from the write port
// rst clears control state and config; the line store is not cleared
// when result is stalled the output register holds and feed.ready drops once
// the prediction stage is also full
module planar_prediction_golomb_context_top
  import pgc_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
  parameter int COEF_BITS     = DEF_COEF_BITS
) (
  input logic         clk,
  input logic         rst,
  pgc_feed_if.sink    feed,
  pgc_result_if.source result,
  pgc_cfg_if.sink     cfg
);

  localparam int CW   = $clog2(MAX_ROW_WIDTH);
  localparam int WW   = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CMPW = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;
  localparam int XW   = (COEF_BITS > SAMPLE_W) ? COEF_BITS : SAMPLE_W;
  localparam int SW   = XW + 3;

  // configuration
  mode_t                  mode;
  logic [ROW_WIDTH_W-1:0] row_width;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ENCODE;
      row_width <= ROW_WIDTH_W'(ROW_WIDTH_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MODE:      mode      <= mode_t'(cfg.data[0]);
        REG_ROW_WIDTH: row_width <= cfg.data;
        default:       ;
      endcase
    end
  end

  logic [CMPW-1:0] w_eff;

  always_comb begin
    if (row_width == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(row_width) > CMPW'(MAX_ROW_WIDTH)) begin
      w_eff = CMPW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = CMPW'(row_width);
    end
  end

  // handshake
  logic s1_valid;
  logic s1_adv;
  logic o_valid;
  logic feed_fire;

  assign s1_adv     = s1_valid && (!o_valid || result.ready);
  assign feed.ready = !s1_valid || s1_adv;
  assign feed_fire  = feed.valid && feed.ready;

  // position tracking at accept
  logic [CW-1:0] col;
  logic          first_row;
  logic [CW-1:0] c_cur;
  logic          fr_cur;
  logic [CW:0]   n_cur;
  logic          wrap;
  logic          first_row_next;

  always_comb begin
    c_cur          = feed.band_start ? '0 : col;
    fr_cur         = feed.band_start || first_row;
    n_cur          = {1'b0, c_cur} + (CW + 1)'(1);
    wrap           = CMPW'(n_cur) >= w_eff;
    first_row_next = fr_cur && !wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
    end else if (feed_fire) begin
      col       <= wrap ? '0 : n_cur[CW-1:0];
      first_row <= first_row_next;
    end
  end

  // line store
  logic [COEF_BITS-1:0] rd_a;
  logic [COEF_BITS-1:0] rd_b;
  logic [COEF_BITS-1:0] cur;
  logic [CW-1:0]        s1_col;

  pgc_line_store #(
    .DEPTH  (MAX_ROW_WIDTH),
    .DATA_W (COEF_BITS)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (s1_adv),
    .wr_addr   (s1_col),
    .wr_data   (cur),
    .rd_en     (feed_fire),
    .rd_addr_a (c_cur),
    .rd_addr_b (n_cur[CW-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // prediction stage
  logic                       s1_first;
  logic                       s1_row0;
  logic                       s1_col0;
  logic                       s1_nk6;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic                       fwd_a;
  logic                       fwd_b;
  logic [COEF_BITS-1:0]       fwd_val;
  logic [COEF_BITS-1:0]       left;
  logic [COEF_BITS-1:0]       topleft;
  logic [COEF_BITS-1:0]       top_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_a    <= 1'b0;
      fwd_b    <= 1'b0;
    end else begin
      if (feed_fire) begin
        s1_valid <= 1'b1;
        fwd_a    <= s1_adv && (s1_col == c_cur);
        fwd_b    <= s1_adv && (s1_col == n_cur[CW-1:0]);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feed_fire) begin
      s1_col   <= c_cur;
      s1_first <= (c_cur == '0) && fr_cur;
      s1_row0  <= fr_cur;
      s1_col0  <= c_cur == '0;
      s1_nk6   <= wrap || first_row_next;
      s1_x     <= feed.sample_in;
      fwd_val  <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left    <= '0;
      topleft <= '0;
    end else if (s1_adv) begin
      left    <= cur;
      topleft <= top_eff;
    end
  end

  logic [COEF_BITS-1:0]       tn_eff;
  logic signed [SW-1:0]       left_s;
  logic signed [SW-1:0]       top_s;
  logic signed [SW-1:0]       tl_s;
  logic signed [SW-1:0]       x_s;
  logic signed [SW-1:0]       pred;
  logic signed [SW-1:0]       res;
  logic signed [SW-1:0]       sum_dec;
  logic signed [SW-1:0]       cur_s;
  logic [COEF_BITS-1:0]       cur_enc;
  logic [SAMPLE_W-1:0]        s1_sample;
  logic                       s1_kind;
  logic [K_W-1:0]             s1_k;

  always_comb begin
    top_eff = fwd_a ? fwd_val : rd_a;
    tn_eff  = fwd_b ? fwd_val : rd_b;
    left_s  = SW'($signed(left));
    top_s   = SW'($signed(top_eff));
    tl_s    = SW'($signed(topleft));
    x_s     = SW'(s1_x);
    cur_enc = x_s[COEF_BITS-1:0];
    s1_kind = KIND_GOLOMB;
    s1_k    = K_EDGE;
    if (s1_first) begin
      pred    = '0;
      s1_kind = KIND_RAW;
      s1_k    = K_NONE;
    end else if (s1_row0) begin
      pred = left_s;
    end else if (s1_col0) begin
      pred = top_s;
    end else begin
      pred = left_s + top_s - tl_s;
      s1_k = activity_k(COEF_MAX_BITS'($signed(left)), COEF_MAX_BITS'($signed(top_eff)),
                        COEF_MAX_BITS'($signed(topleft)));
    end
    sum_dec   = pred + x_s;
    cur       = (mode == MODE_DECODE) ? sum_dec[COEF_BITS-1:0] : cur_enc;
    cur_s     = SW'($signed(cur));
    res       = SW'($signed(cur_enc)) - pred;
    s1_sample = (mode == MODE_DECODE) ? cur_s[SAMPLE_W-1:0] : res[SAMPLE_W-1:0];
  end

  // output register
  logic [SAMPLE_W-1:0]  o_sample;
  logic                 o_kind;
  logic [K_W-1:0]       o_k_enc;
  logic                 o_nk6;
  logic [COEF_BITS-1:0] o_cur;
  logic [COEF_BITS-1:0] o_top;
  logic [COEF_BITS-1:0] o_tn;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_sample <= s1_sample;
      o_kind   <= s1_kind;
      o_k_enc  <= s1_k;
      o_nk6    <= s1_nk6;
      o_cur    <= cur;
      o_top    <= top_eff;
      o_tn     <= tn_eff;
    end
  end

  // decode gives kind and k of the next position
  logic [K_W-1:0] k_dec;

  always_comb begin
    if (o_nk6) begin
      k_dec = K_EDGE;
    end else begin
      k_dec = activity_k(COEF_MAX_BITS'($signed(o_cur)), COEF_MAX_BITS'($signed(o_tn)),
                         COEF_MAX_BITS'($signed(o_top)));
    end
  end

  assign result.valid      = o_valid;
  assign result.sample_out = o_sample;
  assign result.code_kind  = (mode == MODE_DECODE) ? KIND_GOLOMB : o_kind;
  assign result.golomb_k   = (mode == MODE_DECODE) ? k_dec : o_k_enc;

  // checks
  a_band_restart: assert property (@(posedge clk) disable iff (rst)
    feed_fire && feed.band_start |=> s1_valid && s1_col == '0 && s1_row0)
    else $error("band start did not restart at column zero");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_col) && $stable(s1_x))
    else $error("prediction stage changed while stalled");

  a_row0_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(first_row) |-> $past(feed_fire) && col == '0)
    else $error("first row ended away from a row wrap");

  a_raw_k: assert property (@(posedge clk) disable iff (rst)
    result.valid && mode == MODE_ENCODE && result.code_kind == KIND_RAW
      |-> result.golomb_k == K_NONE)
    else $error("raw position carries a nonzero k");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    feed_fire |=> CMPW'(col) < w_eff)
    else $error("column index beyond row width");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for planar_prediction_golomb_context_top
// needs pgc_pkg, the pgc_if channel interfaces and the block's rtl;
// expected residuals, rebuilt coefficients and golomb k come from an in-bench planar predictor
module testbench;
  import pgc_pkg::*;

  localparam int COEF_W         = DEF_COEF_BITS;
  localparam int IDLE_LIMIT     = 5000;
  localparam int MAX_MISMATCH_SHOWN = 10;

  typedef struct {
    bit                         band_start;
    logic signed [SAMPLE_W-1:0] sample;
  } feed_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    code_kind_t                 kind;
    logic [K_W-1:0]             k;
  } coded_out_t;

  logic clk;
  logic rst;

  pgc_feed_if   feed_ch();
  pgc_result_if result_ch();
  pgc_cfg_if    cfg_ch();

  planar_prediction_golomb_context_top dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  feed_item_t coefs_to_send[$];
  coded_out_t predicted_outputs[$];
  int mismatch_count = 0;

  // predictor state
  mode_t                    mode_q      = MODE_ENCODE;
  logic [ROW_WIDTH_W-1:0]   row_width_q = ROW_WIDTH_W'(ROW_WIDTH_RESET);
  logic signed [COEF_W-1:0] line_mem [0:DEF_MAX_ROW_WIDTH-1];
  logic signed [COEF_W-1:0] left_q    = '0;
  logic signed [COEF_W-1:0] topleft_q = '0;
  int                       col_q     = 0;
  bit                       first_row_q = 1'b1;

  int walk_value = 0;
  int last_width = DEF_MAX_ROW_WIDTH;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_width(int w);
    if (w < 1) return 1;
    if (w > DEF_MAX_ROW_WIDTH) return DEF_MAX_ROW_WIDTH;
    return w;
  endfunction

  function automatic logic [K_W-1:0] gradient_k(int l, int t, int tl);
    int a;
    a = ((l > tl) ? l - tl : tl - l) + ((t > tl) ? t - tl : tl - t);
    a = a - (a >>> 2);
    if (a >= ACT_LIMIT) return K_EDGE;
    if (a == 0) return 3'd0;
    if (a == 1) return 3'd1;
    if (a < 4) return 3'd2;
    if (a < 8) return 3'd3;
    if (a < 16) return 3'd4;
    return 3'd5;
  endfunction

  function automatic void predict_planar(bit band_start, logic signed [SAMPLE_W-1:0] din);
    int w, c, n, x, top, pred, sum;
    logic signed [COEF_W-1:0] cur;
    coded_out_t o;
    w = clamp_width(int'(row_width_q));
    if (band_start) begin
      col_q = 0;
      first_row_q = 1'b1;
    end
    c = col_q;
    x = int'(din);
    top = int'(line_mem[c]);
    o.kind = KIND_GOLOMB;
    if (c == 0 && first_row_q) begin
      pred = 0;
      o.kind = KIND_RAW;
      o.k = K_NONE;
    end else if (first_row_q) begin
      pred = int'(left_q);
      o.k = K_EDGE;
    end else if (c == 0) begin
      pred = top;
      o.k = K_EDGE;
    end else begin
      pred = int'(left_q) + top - int'(topleft_q);
      o.k = gradient_k(int'(left_q), top, int'(topleft_q));
    end
    if (mode_q == MODE_ENCODE) begin
      cur = x[COEF_W-1:0];
      sum = int'(cur) - pred;
      o.sample = sum[SAMPLE_W-1:0];
    end else begin
      sum = pred + x;
      cur = sum[COEF_W-1:0];
      o.sample = SAMPLE_W'(cur);
    end
    line_mem[c] = cur;
    topleft_q = top[COEF_W-1:0];
    left_q = cur;
    n = c + 1;
    if (n >= w) begin
      n = 0;
      first_row_q = 1'b0;
    end
    col_q = n;
    // decode reports kind and k for the position after this one
    if (mode_q == MODE_DECODE) begin
      o.kind = KIND_GOLOMB;
      o.k = (n == 0 || first_row_q) ? K_EDGE :
            gradient_k(int'(cur), int'(line_mem[n]), int'(topleft_q));
    end
    predicted_outputs.push_back(o);
  endfunction

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_MISMATCH_SHOWN) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] gen_sample(mode_t m);
    int pick, span, v;
    pick = $urandom_range(0, 99);
    if (pick < 8) return SAMPLE_W'($urandom);
    if (pick < 14) begin
      case ($urandom_range(0, 5))
        0: return -SAMPLE_W'(131072);
        1: return SAMPLE_W'(131071);
        2: return SAMPLE_W'(32767);
        3: return -SAMPLE_W'(32768);
        4: return '0;
        default: return '1;
      endcase
    end
    span = ($urandom_range(0, 2) == 0) ? 3 : (($urandom_range(0, 1) == 1) ? 12 : 48);
    v = int'($urandom_range(0, 2 * span)) - span;
    if (m == MODE_DECODE) return SAMPLE_W'(v);
    walk_value = walk_value + v;
    if (walk_value > 30000 || walk_value < -30000) walk_value = 0;
    return SAMPLE_W'(walk_value);
  endfunction

  // feed driver: bursts of random length with random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      feed_ch.valid <= 1'b0;
    end else begin
      if (feed_ch.valid && feed_ch.ready) begin
        predict_planar(feed_ch.band_start, feed_ch.sample_in);
        void'(coefs_to_send.pop_front());
      end
      if (!(feed_ch.valid && !feed_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          feed_ch.valid <= 1'b0;
        end else if (coefs_to_send.size() > 0) begin
          feed_ch.valid <= 1'b1;
          feed_ch.band_start <= coefs_to_send[0].band_start;
          feed_ch.sample_in <= coefs_to_send[0].sample;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          feed_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, receiver stalls at a level picked at random from 0, 25, 50 or 80 percent
  int stall_pct = 0;
  int stall_cycle = 0;

  always @(posedge clk) begin : result_monitor
    coded_out_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_outputs.size() == 0) begin
          flag_error($sformatf("unexpected item sample_out=%0d kind=%0d k=%0d",
                               result_ch.sample_out, result_ch.code_kind, result_ch.golomb_k));
        end else begin
          want = predicted_outputs.pop_front();
          if (result_ch.sample_out !== want.sample)
            flag_error($sformatf("sample_out expected %0d got %0d",
                                 want.sample, result_ch.sample_out));
          if (result_ch.code_kind !== want.kind)
            flag_error($sformatf("code_kind expected %0d got %0d",
                                 want.kind, result_ch.code_kind));
          if (result_ch.golomb_k !== want.k)
            flag_error($sformatf("golomb_k expected %0d got %0d",
                                 want.k, result_ch.golomb_k));
        end
      end
      stall_cycle++;
      if (stall_cycle % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on cycles without any accepted item
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (coefs_to_send.size() != 0 || predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_phase(mode_t m, int width);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_MODE;
    cfg_ch.data <= ROW_WIDTH_W'(m);
    do @(posedge clk); while (!cfg_ch.ready);
    mode_q = m;
    cfg_ch.index <= REG_ROW_WIDTH;
    cfg_ch.data <= width[ROW_WIDTH_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    row_width_q = width[ROW_WIDTH_W-1:0];
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_item(bit band_start, int value);
    feed_item_t it;
    it.band_start = band_start;
    it.sample = SAMPLE_W'(value);
    coefs_to_send.push_back(it);
  endtask

  // a band may only run on across a width change that does not grow the row
  task automatic run_phase(mode_t m, int width, int count);
    int eff;
    bit bs;
    start_phase(m, width);
    eff = clamp_width(width);
    bs = (eff > last_width) || ($urandom_range(0, 1) == 0);
    last_width = eff;
    for (int i = 0; i < count; i++) begin
      push_item(bs, gen_sample(m));
      bs = ($urandom_range(0, 39) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    feed_ch.valid = 1'b0;
    feed_ch.band_start = 1'b0;
    feed_ch.sample_in = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MODE;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config, first item without band_start still raw
    push_item(1'b0, 131071);
    push_item(1'b0, -131072);
    push_item(1'b0, 32768);
    push_item(1'b0, 0);
    push_item(1'b0, -1);

    // encode, narrow rows: top edge, left edge, interior with high and low activity
    start_phase(MODE_ENCODE, 3);
    push_item(1'b1, 100);
    push_item(1'b0, -32768);
    push_item(1'b0, 32767);
    push_item(1'b0, -32768);
    push_item(1'b0, 32767);
    push_item(1'b0, 50);
    push_item(1'b0, 90);
    push_item(1'b0, 91);
    push_item(1'b0, 92);
    push_item(1'b1, 7);

    // decode, same band continues, extreme residuals wrap the rebuilt value
    start_phase(MODE_DECODE, 3);
    push_item(1'b0, 0);
    push_item(1'b0, 1);
    push_item(1'b0, -1);
    push_item(1'b0, 131071);
    push_item(1'b0, -131072);
    push_item(1'b1, 5);
    push_item(1'b0, 3);
    push_item(1'b0, -2);
    push_item(1'b0, 0);
    push_item(1'b0, 4);
    last_width = 3;

    run_phase(MODE_ENCODE, 1, 20);
    run_phase(MODE_DECODE, 1, 20);
    run_phase(MODE_ENCODE, 7, 40);
    run_phase(MODE_DECODE, 16, 50);
    run_phase(MODE_ENCODE, 0, 15);
    run_phase(MODE_DECODE, 9, 35);
    run_phase(MODE_ENCODE, 5, 30);
    run_phase(MODE_ENCODE, 33, 50);
    run_phase(MODE_DECODE, 2, 30);
    run_phase(MODE_ENCODE, 2047, 30);
    run_phase(MODE_DECODE, 1024, 25);
    run_phase(MODE_ENCODE, 12, 30);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
